// ----- design/saq_pkg.sv -----
// package for the shortest-arc quaternion block
// item structs, result codes, register indexes and pipeline depths; no dependencies
package saq_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 16;
  localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 4;

  localparam logic [15:0] Q_ONE = 16'd16384;

  localparam logic [1:0] CASE_IDENT     = 2'd0;
  localparam logic [1:0] CASE_FALLBACK  = 2'd1;
  localparam logic [1:0] CASE_GENERATED = 2'd2;
  localparam logic [1:0] CASE_GENERAL   = 2'd3;

  localparam logic [1:0] REG_FALLBACK_X = 2'd0;
  localparam logic [1:0] REG_FALLBACK_Y = 2'd1;
  localparam logic [1:0] REG_FALLBACK_Z = 2'd2;

  typedef struct packed {
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic signed [15:0] src_z;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic signed [15:0] dst_z;
  } saq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [1:0]         result_case;
  } saq_out_t;

  typedef logic [3:0][31:0] comp4_t;
  typedef logic [3:0][15:0] q4_t;

  function automatic logic [31:0] sx32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ----- design/saq_norm.sv -----
// pipelined normalizer: sum of squares, square root one bit per stage,
// rounded division one quotient bit per stage, clamp to q1.14; uses saq_pkg
module saq_norm import saq_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  logic   gen_i,
  input  comp4_t comp_i,
  output q4_t    q_o
);

  logic [3:0][31:0] mag_a_q;
  logic [3:0]       neg_a_q;
  logic [3:0][63:0] sq_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        neg_a_q[i] <= comp_i[i][31];
        mag_a_q[i] <= comp_i[i][31] ? (32'd0 - comp_i[i]) : comp_i[i];
        sq_a_q[i]  <= $signed({{32{comp_i[i][31]}}, comp_i[i]})
                    * $signed({{32{comp_i[i][31]}}, comp_i[i]});
      end
    end
  end

  logic [63:0]      x_q     [0:SQRT_STEPS];
  logic [63:0]      r_q     [0:SQRT_STEPS];
  logic [3:0][31:0] mag_s_q [0:SQRT_STEPS];
  logic [3:0]       neg_s_q [0:SQRT_STEPS];
  logic [63:0]      sum_d;

  assign sum_d = sq_a_q[0] + sq_a_q[1] + sq_a_q[2] + sq_a_q[3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]     <= gen_i ? sum_d : {sum_d[47:0], 16'd0};
      r_q[0]     <= '0;
      mag_s_q[0] <= mag_a_q;
      neg_s_q[0] <= neg_a_q;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = r_q[k] + BITV;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x_q[k] >= trial) begin
          x_q[k+1] <= x_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + BITV;
        end else begin
          x_q[k+1] <= x_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
        mag_s_q[k+1] <= mag_s_q[k];
        neg_s_q[k+1] <= neg_s_q[k];
      end
    end
  end

  logic [31:0]      den_q [0:DIV_STEPS];
  logic [3:0][47:0] rem_q [0:DIV_STEPS];
  logic [3:0][15:0] quo_q [0:DIV_STEPS];
  logic [3:0]       neg_d_q [0:DIV_STEPS];
  logic [31:0]      root;
  logic [31:0]      den_d;

  assign root  = r_q[SQRT_STEPS][31:0];
  assign den_d = (root == 32'd0) ? 32'd1 : root;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]   <= den_d;
      neg_d_q[0] <= neg_s_q[SQRT_STEPS];
      quo_q[0]   <= '0;
      for (int i = 0; i < 4; i++) begin
        rem_q[0][i] <= (gen_i ? (48'(mag_s_q[SQRT_STEPS][i]) << 14)
                              : (48'(mag_s_q[SQRT_STEPS][i]) << 22))
                     + 48'(den_d[31:1]);
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [47:0] dsh;
    assign dsh = 48'(den_q[j]) << SH;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j+1]   <= den_q[j];
        neg_d_q[j+1] <= neg_d_q[j];
        for (int i = 0; i < 4; i++) begin
          if (rem_q[j][i] >= dsh) begin
            rem_q[j+1][i] <= rem_q[j][i] - dsh;
            quo_q[j+1][i] <= {quo_q[j][i][14:0], 1'b1};
          end else begin
            rem_q[j+1][i] <= rem_q[j][i];
            quo_q[j+1][i] <= {quo_q[j][i][14:0], 1'b0};
          end
        end
      end
    end
  end

  logic [3:0][15:0] clamp_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      clamp_d[i] = (quo_q[DIV_STEPS][i] > Q_ONE) ? Q_ONE : quo_q[DIV_STEPS][i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        q_o[i] <= neg_d_q[DIV_STEPS][i] ? (16'd0 - clamp_d[i]) : clamp_d[i];
      end
    end
  end

endmodule

// ----- design/shortest_arc_quaternion.sv -----
// shortest-arc rotation quaternion, top level
// two normalizer passes around a dot/cross stage and an output skid; uses saq_pkg, saq_norm
//
// usage: items enter on in_valid_i/in_stall_o with a source and destination vector,
// results leave on out_valid_o/out_stall_i as a q1.14 quaternion plus a case code.
// an item is taken when valid is high and stall is low.
// throughput is one item per cycle while the pipeline is not frozen; every
// step (square-root bit, quotient bit, product, sum) has a register stage of
// its own, and all stages advance together.
// when the receiver stalls, the output register holds and one more item lands in
// the skid register; then in_stall_o rises and the whole pipeline freezes until
// the skid register drains. nothing is dropped or repeated.
// fallback axis registers are written on cfg_valid_i/cfg_ready_o (always ready),
// index 0..2 for x, y, z; index 3 is ignored. write them only while the block is idle.
// reset clears all valid bits and sets the fallback axis to (1, 0, 0).
module shortest_arc_quaternion import saq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  saq_in_t     in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output saq_out_t    out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef struct packed {
    logic       v;
    logic       zero;
    logic [1:0] akind;
  } p1_side_t;

  typedef struct packed {
    logic             v;
    logic [1:0]       rcase;
    logic [2:0][15:0] na;
  } p2_side_t;

  localparam logic [31:0] W_BIAS = 32'h1000_0000;

  logic [15:0] fb_x_q, fb_y_q, fb_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_x_q <= 16'd1;
      fb_y_q <= 16'd0;
      fb_z_q <= 16'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FALLBACK_X: fb_x_q <= cfg_data_i;
        REG_FALLBACK_Y: fb_y_q <= cfg_data_i;
        REG_FALLBACK_Z: fb_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q, out_v_q;
  assign en         = !skid_v_q;
  assign in_stall_o = !en;

  // stage a: input register
  saq_in_t in_q;
  logic    a_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (en) a_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_i;
  end

  logic   src_zero, dst_zero, fb_zero, gen_alt;
  comp4_t src_c, dst_c, axis_c;
  logic [1:0] akind;

  assign src_zero = (in_q.src_x == 16'sd0) && (in_q.src_y == 16'sd0) && (in_q.src_z == 16'sd0);
  assign dst_zero = (in_q.dst_x == 16'sd0) && (in_q.dst_y == 16'sd0) && (in_q.dst_z == 16'sd0);
  assign fb_zero  = (fb_x_q == 16'd0) && (fb_y_q == 16'd0) && (fb_z_q == 16'd0);
  assign gen_alt  = (in_q.src_z == 16'sd0) && (in_q.src_y == 16'sd0);

  always_comb begin
    src_c = {32'd0, sx32(in_q.src_z), sx32(in_q.src_y), sx32(in_q.src_x)};
    dst_c = {32'd0, sx32(in_q.dst_z), sx32(in_q.dst_y), sx32(in_q.dst_x)};
    if (!fb_zero) begin
      akind  = CASE_FALLBACK;
      axis_c = {32'd0, sx32(fb_z_q), sx32(fb_y_q), sx32(fb_x_q)};
    end else if (!gen_alt) begin
      akind  = CASE_GENERATED;
      axis_c = {32'd0, sx32(in_q.src_y), 32'd0 - sx32(in_q.src_z), 32'd0};
    end else begin
      akind  = CASE_GENERATED;
      axis_c = {32'd0, 32'd0 - sx32(in_q.src_x), 32'd0, sx32(in_q.src_z)};
    end
  end

  q4_t n0, n1, na;

  saq_norm u_norm_src (.clk_i, .en_i(en), .gen_i(1'b0), .comp_i(src_c),  .q_o(n0));
  saq_norm u_norm_dst (.clk_i, .en_i(en), .gen_i(1'b0), .comp_i(dst_c),  .q_o(n1));
  saq_norm u_norm_ax  (.clk_i, .en_i(en), .gen_i(1'b0), .comp_i(axis_c), .q_o(na));

  p1_side_t p1_q [0:NORM_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NORM_LAT; k++) p1_q[k] <= '0;
    end else if (en) begin
      p1_q[0] <= '{v: a_v_q, zero: src_zero || dst_zero, akind: akind};
      for (int k = 1; k < NORM_LAT; k++) p1_q[k] <= p1_q[k-1];
    end
  end

  // stage b: the nine products
  logic [2:0][2:0][31:0] prod_q;
  logic [2:0][15:0]      na_b_q, na_c_q, na_d_q;
  p1_side_t              b_q, c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= $signed(n0[i]) * $signed(n1[j]);
        end
        na_b_q[i] <= na[i];
      end
    end
  end

  // stage c: dot and cross
  logic [31:0] d28_q;
  logic [2:0][31:0] cr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d28_q    <= prod_q[0][0] + prod_q[1][1] + prod_q[2][2];
      cr_q[0]  <= prod_q[1][2] - prod_q[2][1];
      cr_q[1]  <= prod_q[2][0] - prod_q[0][2];
      cr_q[2]  <= prod_q[0][1] - prod_q[1][0];
      na_c_q   <= na_b_q;
    end
  end

  // stage d: classify and form w
  logic [31:0] dmag, dq;
  logic        d_same, d_opp;
  logic [1:0]  rcase_d;
  logic        d_v_q;
  logic [1:0]  rcase_q;
  comp4_t      gen_c_q;

  assign dmag   = d28_q[31] ? (32'd0 - d28_q) : d28_q;
  assign dq     = (dmag + 32'd8192) >> 14;
  assign d_same = !d28_q[31] && (dq >= 32'd16384);
  assign d_opp  = d28_q[31] && (dq >= 32'd16383);

  always_comb begin
    priority if (c_q.zero || d_same) rcase_d = CASE_IDENT;
    else if (d_opp)                  rcase_d = c_q.akind;
    else                             rcase_d = CASE_GENERAL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q   <= '0;
      c_q   <= '0;
      d_v_q <= 1'b0;
    end else if (en) begin
      b_q   <= p1_q[NORM_LAT-1];
      c_q   <= b_q;
      d_v_q <= c_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rcase_q <= rcase_d;
      gen_c_q <= {W_BIAS + d28_q, cr_q[2], cr_q[1], cr_q[0]};
      na_d_q  <= na_c_q;
    end
  end

  q4_t qg;

  saq_norm u_norm_q (.clk_i, .en_i(en), .gen_i(1'b1), .comp_i(gen_c_q), .q_o(qg));

  p2_side_t p2_q [0:NORM_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NORM_LAT; k++) p2_q[k] <= '0;
    end else if (en) begin
      p2_q[0] <= '{v: d_v_q, rcase: rcase_q, na: na_d_q};
      for (int k = 1; k < NORM_LAT; k++) p2_q[k] <= p2_q[k-1];
    end
  end

  p2_side_t pend;
  saq_out_t pdata;
  logic     pv;

  assign pend = p2_q[NORM_LAT-1];
  assign pv   = pend.v;

  always_comb begin
    pdata.result_case = pend.rcase;
    unique case (pend.rcase)
      CASE_IDENT: begin
        pdata.quat_x = '0;
        pdata.quat_y = '0;
        pdata.quat_z = '0;
        pdata.quat_w = Q_ONE;
      end
      CASE_FALLBACK, CASE_GENERATED: begin
        pdata.quat_x = pend.na[0];
        pdata.quat_y = pend.na[1];
        pdata.quat_z = pend.na[2];
        pdata.quat_w = '0;
      end
      default: begin
        pdata.quat_x = qg[0];
        pdata.quat_y = qg[1];
        pdata.quat_z = qg[2];
        pdata.quat_w = qg[3];
      end
    endcase
  end

  // output register and skid register
  saq_out_t out_q, skid_q;
  logic     out_blocked;

  assign out_blocked = out_v_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_blocked) begin
      if (en && pv) skid_v_q <= 1'b1;
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q <= pv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_blocked) begin
      if (en && pv) skid_q <= pdata;
    end else if (skid_v_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= pdata;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled while output was free");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(p2_q[NORM_LAT-1]) && $stable(p1_q[NORM_LAT-1]))
    else $error("pipeline moved while frozen");

  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.result_case == CASE_IDENT)
      |-> (out_q.quat_w == Q_ONE) && (out_q.quat_x == 16'sd0))
    else $error("identity result malformed");

  a_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && ((out_q.result_case == CASE_FALLBACK)
             || (out_q.result_case == CASE_GENERATED)) |-> (out_q.quat_w == 16'sd0))
    else $error("half-turn result has nonzero w");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_stall_i |=> !skid_v_q && out_v_q)
    else $error("skid did not drain");

endmodule
